// File: rtl/core/lfrs_pkg.sv
// ----------------------------------------------------------------------------
// lfrs_pkg: shared types, constants and microcode for the row serializer
// Beat types, protocol bytes and the read-only control program.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrs_pkg;

  // Frame store geometry (fixed by the address field width)
  localparam int STORE_AW    = 10;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // Defaults for the top-level parameters
  localparam int DEF_ROWS          = 64;
  localparam int DEF_BYTES_PER_ROW = 16;

  // Serial protocol bytes
  localparam logic [7:0] START_CMD      = 8'hF8;
  localparam logic [7:0] START_DATA     = 8'hFA;
  localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;
  localparam logic [7:0] NIBBLE_LO_MASK = 8'h0F;
  localparam logic [7:0] ADDR_BASE      = 8'h80;
  localparam logic [7:0] ADDR_LOWER     = 8'h88;

  // Input item mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SHOW  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [9:0] address;
    logic [7:0] data;
    logic [5:0] row;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       end_of_row;
  } out_beat_t;

  // Microcode
  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_VERT_ST   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_VERT_HI   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_VERT_LO   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_HORIZ_ST  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_HORIZ_HI  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_HORIZ_LO  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DATA_ST   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DATA_HI   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DATA_LO   = 4'd9;

  typedef enum logic [1:0] {
    BSEL_START_CMD,
    BSEL_START_DATA,
    BSEL_HI,
    BSEL_LO
  } byte_sel_e;

  typedef enum logic [1:0] {
    SRC_VERT,
    SRC_HORIZ,
    SRC_DATA
  } src_sel_e;

  typedef enum logic [1:0] {
    OP_WAIT,   // hold until a show item starts
    OP_NEXT,   // fall through to the next step
    OP_LOOP    // jump to target while columns remain, else back to idle
  } seq_op_e;

  typedef struct packed {
    logic              emit;
    byte_sel_e         bsel;
    src_sel_e          src;
    logic              rd_en;
    logic              col_step;
    logic              last_beat;
    seq_op_e           op;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;     // show item accepted this cycle
    logic adv;       // output slot free, step may proceed
    logic col_last;  // column counter at the final column
  } seq_stat_t;

  localparam ctrl_t CTRL_IDLE = '{
    emit: 1'b0, bsel: BSEL_START_CMD, src: SRC_VERT, rd_en: 1'b0,
    col_step: 1'b0, last_beat: 1'b0, op: OP_WAIT, target: STEP_IDLE
  };

  // Control ROM: one word per step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w = CTRL_IDLE;
      end
      STEP_VERT_ST: begin
        w.emit = 1'b1; w.bsel = BSEL_START_CMD; w.src = SRC_VERT; w.op = OP_NEXT;
      end
      STEP_VERT_HI: begin
        w.emit = 1'b1; w.bsel = BSEL_HI; w.src = SRC_VERT; w.op = OP_NEXT;
      end
      STEP_VERT_LO: begin
        w.emit = 1'b1; w.bsel = BSEL_LO; w.src = SRC_VERT; w.op = OP_NEXT;
      end
      STEP_HORIZ_ST: begin
        w.emit = 1'b1; w.bsel = BSEL_START_CMD; w.src = SRC_HORIZ; w.op = OP_NEXT;
      end
      STEP_HORIZ_HI: begin
        w.emit = 1'b1; w.bsel = BSEL_HI; w.src = SRC_HORIZ; w.op = OP_NEXT;
      end
      STEP_HORIZ_LO: begin
        w.emit = 1'b1; w.bsel = BSEL_LO; w.src = SRC_HORIZ; w.op = OP_NEXT;
      end
      STEP_DATA_ST: begin
        w.emit = 1'b1; w.bsel = BSEL_START_DATA; w.src = SRC_DATA; w.rd_en = 1'b1;
        w.op = OP_NEXT;
      end
      STEP_DATA_HI: begin
        w.emit = 1'b1; w.bsel = BSEL_HI; w.src = SRC_DATA; w.op = OP_NEXT;
      end
      STEP_DATA_LO: begin
        w.emit = 1'b1; w.bsel = BSEL_LO; w.src = SRC_DATA; w.col_step = 1'b1;
        w.last_beat = 1'b1; w.op = OP_LOOP; w.target = STEP_DATA_ST;
      end
      default: begin
        w = CTRL_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcd_frame_refresh_serializer.sv
// ----------------------------------------------------------------------------
// lcd_frame_refresh_serializer: frame store with serial row refresh
// Stores frame bytes and streams one row as three-byte serial frames.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake               | beat
//   --------+-----+-------------------------+---------------------------------
//   in      | in  | in_valid_i / in_ready_o | in_beat_t  (mode,address,data,row)
//   out     | out | out_valid_o/out_ready_i | out_beat_t (serial_byte,end_of_row)
//
// Write item: accepted while the sequencer is idle, stored at once.
// Show item: 3*(2+BYTES_PER_ROW) beats (54 at defaults), one per microcode step;
//   the control program emits one beat per step.
// A sink stall freezes the step counter; the output register holds the beat.
// Reset clears the step counter and output valid; the frame store is not
// cleared and reads of never-written bytes return whatever the RAM holds.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_frame_refresh_serializer #(
  parameter int ROWS          = lfrs_pkg::DEF_ROWS,
  parameter int BYTES_PER_ROW = lfrs_pkg::DEF_BYTES_PER_ROW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lfrs_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lfrs_pkg::out_beat_t      out_data_o
);

  localparam int HALF_ROWS = ROWS / 2;
  localparam int COL_W     = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int AW        = lfrs_pkg::STORE_AW;

  // row modulo ROWS: restoring compare/subtract, six narrow steps
  function automatic logic [5:0] row_wrap(input logic [5:0] r);
    logic [12:0] v;
    v = 13'(r);
    for (int k = 5; k >= 0; k--) begin
      if (v >= (13'(ROWS) << k)) v = v - (13'(ROWS) << k);
    end
    return v[5:0];
  endfunction

  lfrs_pkg::ctrl_t     ctrl;
  lfrs_pkg::seq_stat_t stat;
  logic                seq_idle;

  logic                in_acc;
  logic                start;
  logic                adv;
  logic                col_last;

  logic [5:0]          row_mod;
  logic                row_lower;
  logic [7:0]          vert_q, horiz_q;
  logic [COL_W-1:0]    col_q;
  logic [AW-1:0]       addr_q;
  logic [7:0]          rdata;

  logic [7:0]          src_val;
  logic [7:0]          byte_val;

  logic                out_valid_q;
  lfrs_pkg::out_beat_t out_q;

  // --- handshake -----------------------------------------------------------
  assign in_ready_o = seq_idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && (in_data_i.mode == lfrs_pkg::MODE_SHOW);
  // a step may run when the output register is empty or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign col_last   = (col_q == COL_W'(BYTES_PER_ROW - 1));

  assign stat = '{start: start, adv: adv, col_last: col_last};

  lfrs_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .idle_o (seq_idle)
  );

  // --- frame store -----------------------------------------------------------
  lfrs_frame_store u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_data_i.mode == lfrs_pkg::MODE_WRITE)),
    .waddr_i (in_data_i.address),
    .wdata_i (in_data_i.data),
    .re_i    (ctrl.rd_en && adv),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // --- row setup: display addresses and base address -----------------------
  assign row_mod   = row_wrap(in_data_i.row);
  assign row_lower = (7'(row_mod) >= 7'(HALF_ROWS));

  always_ff @(posedge clk_i) begin
    if (start) begin
      vert_q  <= lfrs_pkg::ADDR_BASE +
                 (row_lower ? 8'(row_mod) - 8'(HALF_ROWS) : 8'(row_mod));
      horiz_q <= row_lower ? lfrs_pkg::ADDR_LOWER : lfrs_pkg::ADDR_BASE;
      // base address wraps at the store size
      addr_q  <= AW'(16'(row_mod) * 16'(BYTES_PER_ROW));
      col_q   <= '0;
    end else if (ctrl.col_step && adv) begin
      addr_q  <= addr_q + AW'(1);
      col_q   <= col_q + COL_W'(1);
    end
  end

  // --- byte formatter ------------------------------------------------------
  always_comb begin
    case (ctrl.src)
      lfrs_pkg::SRC_VERT:  src_val = vert_q;
      lfrs_pkg::SRC_HORIZ: src_val = horiz_q;
      lfrs_pkg::SRC_DATA:  src_val = rdata;
      default:             src_val = vert_q;
    endcase
  end

  always_comb begin
    case (ctrl.bsel)
      lfrs_pkg::BSEL_START_CMD:  byte_val = lfrs_pkg::START_CMD;
      lfrs_pkg::BSEL_START_DATA: byte_val = lfrs_pkg::START_DATA;
      lfrs_pkg::BSEL_HI:         byte_val = src_val & lfrs_pkg::NIBBLE_HI_MASK;
      lfrs_pkg::BSEL_LO:         byte_val = (src_val & lfrs_pkg::NIBBLE_LO_MASK) << 4;
      default:                   byte_val = lfrs_pkg::START_CMD;
    endcase
  end

  // --- output register -----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && adv) begin
      out_q.serial_byte <= byte_val;
      out_q.end_of_row  <= ctrl.last_beat && col_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // a show item keeps the input closed on the next cycle
  a_show_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == lfrs_pkg::MODE_SHOW)
    |=> !in_ready_o)
    else $error("input ready right after a show item");

  // the closing beat of a row is always a low-nibble byte
  a_eor_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_row |-> (out_data_o.serial_byte[3:0] == 4'h0))
    else $error("end of row on a start byte");

  // the sequencer neither reads the store nor emits a beat while idle
  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ctrl.rd_en && !ctrl.emit)
    else $error("idle step with datapath activity");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lfrs_frame_store.sv
// ----------------------------------------------------------------------------
// lfrs_frame_store: frame byte memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_frame_store (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [lfrs_pkg::STORE_AW-1:0] waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic                          re_i,
  input  wire logic [lfrs_pkg::STORE_AW-1:0] raddr_i,
  output logic      [7:0]                    rdata_o
);

  logic [7:0] mem_q [lfrs_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read, so a stalled step still sees it
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/lfrs_sequencer.sv
// ----------------------------------------------------------------------------
// lfrs_sequencer: step counter over the control ROM
// Issues one control word per step; handles wait, fall-through and loop.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_sequencer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lfrs_pkg::seq_stat_t stat_i,
  output lfrs_pkg::ctrl_t          ctrl_o,
  output logic                     idle_o
);

  logic [lfrs_pkg::STEP_W-1:0] step_q, step_d;
  lfrs_pkg::ctrl_t             ctrl;

  assign ctrl = lfrs_pkg::ucode(step_q);

  always_comb begin
    step_d = step_q;
    unique case (ctrl.op)
      lfrs_pkg::OP_WAIT: begin
        if (stat_i.start) step_d = lfrs_pkg::STEP_VERT_ST;
      end
      lfrs_pkg::OP_NEXT: begin
        if (stat_i.adv) step_d = step_q + lfrs_pkg::STEP_W'(1);
      end
      lfrs_pkg::OP_LOOP: begin
        if (stat_i.adv) step_d = stat_i.col_last ? lfrs_pkg::STEP_IDLE : ctrl.target;
      end
      default: begin
        step_d = lfrs_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lfrs_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign idle_o = (ctrl.op == lfrs_pkg::OP_WAIT);

endmodule

`default_nettype wire
